/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
// Depends on nothing; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as its trigger.
`define ASSERT_SAME(lbl, clk, rst_n, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error("assertion failed in the same cycle");

// Condition must hold in the cycle after its trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("assertion failed one cycle later");

`endif

/* hdl/tbs_pkg.sv */
// Package for the terminal byte to scan code decoder: codes, types and the
// plain byte decode function. Depends on nothing.
package tbs_pkg;

	// Result queue geometry.
	localparam int QDepth = 4;
	localparam int QAw = $clog2(QDepth);
	localparam int QCw = $clog2(QDepth + 1);
	// Room for the two results that one byte can cause.
	localparam logic [QCw-1:0] QRoomMax = QCw'(QDepth - 2);

	// Byte codes of the terminal stream.
	localparam logic [7:0] ChrEsc     = 8'h1b;
	localparam logic [7:0] ChrLbrack  = 8'h5b;
	localparam logic [7:0] ChrCr      = 8'h0d;
	localparam logic [7:0] ChrLf      = 8'h0a;
	localparam logic [7:0] ChrBs      = 8'h08;
	localparam logic [7:0] ChrTab     = 8'h09;
	localparam logic [7:0] ChrDel     = 8'h7f;
	localparam logic [7:0] ChrSpace   = 8'h20;
	localparam logic [7:0] ChrArrowUp = 8'h41;
	localparam logic [7:0] ChrArrowDn = 8'h42;
	localparam logic [7:0] ChrArrowRt = 8'h43;
	localparam logic [7:0] ChrArrowLt = 8'h44;

	// Set-1 make codes.
	localparam logic [6:0] ScanEsc   = 7'h01;
	localparam logic [6:0] ScanZero  = 7'h0b;
	localparam logic [6:0] ScanBs    = 7'h0e;
	localparam logic [6:0] ScanTab   = 7'h0f;
	localparam logic [6:0] ScanEnter = 7'h1c;
	localparam logic [6:0] ScanSpace = 7'h39;
	localparam logic [6:0] ScanUp    = 7'h48;
	localparam logic [6:0] ScanDown  = 7'h50;
	localparam logic [6:0] ScanRight = 7'h4d;
	localparam logic [6:0] ScanLeft  = 7'h4b;

	// Escape tracker phases.
	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_ESC  = 3'b010,
		PH_CSI  = 3'b100
	} phase_t;

	// One key event with its hit flag.
	typedef struct packed {
		logic       hit;
		logic [7:0] ascii;
		logic [6:0] scan;
	} key_t;

	// One queued result.
	typedef struct packed {
		logic [7:0] ascii;
		logic [6:0] scan;
		logic       last;
	} entry_t;

	// Scan code of the letter keys, indexed from a (0) to z (25).
	function automatic logic [6:0] letter_make_code(input logic [4:0] idx);
		logic [6:0] s;
		case (idx)
			5'd0:    s = 7'h1e;
			5'd1:    s = 7'h30;
			5'd2:    s = 7'h2e;
			5'd3:    s = 7'h20;
			5'd4:    s = 7'h12;
			5'd5:    s = 7'h21;
			5'd6:    s = 7'h22;
			5'd7:    s = 7'h23;
			5'd8:    s = 7'h17;
			5'd9:    s = 7'h24;
			5'd10:   s = 7'h25;
			5'd11:   s = 7'h26;
			5'd12:   s = 7'h32;
			5'd13:   s = 7'h31;
			5'd14:   s = 7'h18;
			5'd15:   s = 7'h19;
			5'd16:   s = 7'h10;
			5'd17:   s = 7'h13;
			5'd18:   s = 7'h1f;
			5'd19:   s = 7'h14;
			5'd20:   s = 7'h16;
			5'd21:   s = 7'h2f;
			5'd22:   s = 7'h11;
			5'd23:   s = 7'h2d;
			5'd24:   s = 7'h15;
			5'd25:   s = 7'h2c;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

	// Plain decode of one byte outside any escape sequence.
	function automatic key_t decode_plain(input logic [7:0] b);
		key_t k;
		k.ascii = b;
		k.scan  = 7'h00;
		case (b) inside
			ChrCr, ChrLf: begin
				k.ascii = ChrCr;
				k.scan  = ScanEnter;
			end
			ChrBs, ChrDel: begin
				k.ascii = ChrBs;
				k.scan  = ScanBs;
			end
			ChrTab:   k.scan = ScanTab;
			ChrEsc:   k.scan = ScanEsc;
			// Control letters and both letter cases share the low five bits.
			[8'h01:8'h1a], [8'h41:8'h5a], [8'h61:8'h7a]:
				k.scan = letter_make_code(b[4:0] - 5'd1);
			[8'h31:8'h39]: k.scan = {3'b000, b[3:0]} + 7'd1;
			8'h30:    k.scan = ScanZero;
			ChrSpace: k.scan = ScanSpace;
			// Shifted digits sit on the digit keys.
			8'h21:    k.scan = 7'h02;
			8'h40:    k.scan = 7'h03;
			8'h23:    k.scan = 7'h04;
			8'h24:    k.scan = 7'h05;
			8'h25:    k.scan = 7'h06;
			8'h5e:    k.scan = 7'h07;
			8'h26:    k.scan = 7'h08;
			8'h2a:    k.scan = 7'h09;
			8'h28:    k.scan = 7'h0a;
			8'h29:    k.scan = ScanZero;
			// Punctuation, plain and shifted on the same key.
			8'h2d, 8'h5f: k.scan = 7'h0c;
			8'h3d, 8'h2b: k.scan = 7'h0d;
			8'h5b, 8'h7b: k.scan = 7'h1a;
			8'h5d, 8'h7d: k.scan = 7'h1b;
			8'h3b, 8'h3a: k.scan = 7'h27;
			8'h27, 8'h22: k.scan = 7'h28;
			8'h60, 8'h7e: k.scan = 7'h29;
			8'h5c, 8'h7c: k.scan = 7'h2b;
			8'h2c, 8'h3c: k.scan = 7'h33;
			8'h2e, 8'h3e: k.scan = 7'h34;
			8'h2f, 8'h3f: k.scan = 7'h35;
			default:  k.scan = 7'h00;
		endcase
		k.hit = (k.scan != 7'h00);
		return k;
	endfunction

endpackage

/* hdl/terminal_byte_to_scancode.sv */
// Top level of the terminal byte to PC scan code decoder.
// Depends on tbs_pkg for codes, types and the plain decode function.

// One terminal byte is taken per clock cycle while in_stall is low. A byte
// waits in the input register, where it is decoded together with the escape
// phase, until the queue has room, and its zero, one or two key events are
// then written into a four-entry result queue, whose head drives the result
// channel.
// Each result leaves the queue in a cycle of its own, so a byte that gives
// two key events (ESC followed by another key) leaves as two results.
// in_stall rises only when the queue has less than two free entries with a
// byte waiting in the input register.
module terminal_byte_to_scancode (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] key_ascii,
	output logic [6:0] key_scan,
	output logic       last_of_run
);

	logic                      valid_s1;
	logic [7:0]                byte_s1;
	tbs_pkg::phase_t           phase_q;
	tbs_pkg::phase_t           phase_d;
	tbs_pkg::entry_t           queue_q [tbs_pkg::QDepth];
	logic [tbs_pkg::QAw-1:0]   wr_ptr_q;
	logic [tbs_pkg::QAw-1:0]   rd_ptr_q;
	logic [tbs_pkg::QCw-1:0]   count_q;
	logic                      drain;
	logic                      pop;
	logic [1:0]                n_push;
	tbs_pkg::key_t             plain;
	tbs_pkg::entry_t           res0;
	tbs_pkg::entry_t           res1;
	tbs_pkg::entry_t           head;

	// The input register drains once the queue has room for two results.
	assign drain    = valid_s1 && (count_q <= tbs_pkg::QRoomMax);
	assign in_stall = valid_s1 && !drain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	// Decode of the registered byte against the escape phase.
	always_comb begin
		plain   = tbs_pkg::decode_plain(byte_s1);
		phase_d = phase_q;
		n_push  = 2'd0;
		res0    = '{ascii: tbs_pkg::ChrEsc, scan: tbs_pkg::ScanEsc, last: 1'b1};
		res1    = '{ascii: plain.ascii, scan: plain.scan, last: 1'b1};
		case (phase_q)
			tbs_pkg::PH_IDLE: begin
				if (byte_s1 == tbs_pkg::ChrEsc) begin
					phase_d = tbs_pkg::PH_ESC;
				end else if (plain.hit) begin
					res0   = '{ascii: plain.ascii, scan: plain.scan, last: 1'b1};
					n_push = 2'd1;
				end
			end
			tbs_pkg::PH_ESC: begin
				if (byte_s1 == tbs_pkg::ChrLbrack) begin
					phase_d = tbs_pkg::PH_CSI;
				end else begin
					phase_d = tbs_pkg::PH_IDLE;
					// A pending ESC goes out first; a second ESC adds nothing.
					if (byte_s1 != tbs_pkg::ChrEsc && plain.hit) begin
						res0.last = 1'b0;
						n_push    = 2'd2;
					end else begin
						n_push = 2'd1;
					end
				end
			end
			tbs_pkg::PH_CSI: begin
				phase_d    = tbs_pkg::PH_IDLE;
				res0.ascii = 8'h00;
				n_push     = 2'd1;
				case (byte_s1)
					tbs_pkg::ChrArrowUp: res0.scan = tbs_pkg::ScanUp;
					tbs_pkg::ChrArrowDn: res0.scan = tbs_pkg::ScanDown;
					tbs_pkg::ChrArrowRt: res0.scan = tbs_pkg::ScanRight;
					tbs_pkg::ChrArrowLt: res0.scan = tbs_pkg::ScanLeft;
					default:             n_push    = 2'd0;
				endcase
			end
			default: begin
				phase_d = tbs_pkg::PH_IDLE;
			end
		endcase
	end

	// Escape phase advances with each byte taken from the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tbs_pkg::PH_IDLE;
		end else if (drain) begin
			phase_q <= phase_d;
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (drain && n_push != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (drain && n_push == 2'd2) begin
			queue_q[wr_ptr_q + tbs_pkg::QAw'(1)] <= res1;
		end
	end

	assign pop = out_valid && !out_stall;

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (drain) begin
				wr_ptr_q <= wr_ptr_q + tbs_pkg::QAw'(n_push);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + tbs_pkg::QAw'(1);
			end
			count_q <= count_q + (drain ? tbs_pkg::QCw'(n_push) : '0)
				- tbs_pkg::QCw'(pop);
		end
	end

	// Head of the queue drives the result channel.
	assign head        = queue_q[rd_ptr_q];
	assign out_valid   = (count_q != '0);
	assign key_ascii   = head.ascii;
	assign key_scan    = head.scan;
	assign last_of_run = head.last;

endmodule

/* hdl/tbs_checker.sv */
// Port-level checker for the terminal byte to scan code decoder, bound to it.
// Depends on tbs_pkg and on the assertion macros header.
`include "assert_macros.svh"

module tbs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] key_ascii,
	input logic [6:0] key_scan,
	input logic       last_of_run
);

	logic [15:0] head_bits;
	logic        esc_key;
	logic        arrow_key;

	// Views of the offered result used by the properties below.
	assign head_bits = {key_ascii, key_scan, last_of_run};
	assign esc_key   = (key_ascii == tbs_pkg::ChrEsc) && (key_scan == tbs_pkg::ScanEsc);
	assign arrow_key = (key_scan == tbs_pkg::ScanUp) || (key_scan == tbs_pkg::ScanDown)
		|| (key_scan == tbs_pkg::ScanRight) || (key_scan == tbs_pkg::ScanLeft);

	// A stalled result stays offered and unchanged.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(head_bits))

	// Every key event carries a real make code.
	`ASSERT_SAME(a_scan_nonzero, clk, arst_n, out_valid, key_scan != 7'h00)

	// Only the pending ESC key can precede another key of the same byte.
	`ASSERT_SAME(a_first_is_esc, clk, arst_n, out_valid && !last_of_run, esc_key)

	// Arrow keys, the only events with ascii zero, end their run.
	`ASSERT_SAME(a_arrow_last, clk, arst_n, out_valid && key_ascii == 8'h00, last_of_run && arrow_key)

endmodule

bind terminal_byte_to_scancode tbs_checker u_tbs_checker (.*);
